@@ design/chs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants of the chip health supervisor
// Per-chip state record, poll and result records, configuration set and the
// register indexes of the configuration port.
// ----------------------------------------------------------------------------
package chs_pkg;

  typedef enum logic [1:0] {
    MODE_RUN       = 2'd0,
    MODE_HIB_PEND  = 2'd1,
    MODE_HIBERNATE = 2'd2
  } mode_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIBERNATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORK_TMO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd3;

  localparam logic [15:0] RST_THRESHOLD   = 16'd3;
  localparam logic [31:0] RST_HIBERNATE   = 32'd10000;
  localparam logic [31:0] RST_WORK_TMO    = 32'd5000;
  localparam logic [15:0] RST_ENABLE_MASK = 16'hFFFF;

  // Half of a 0.16 fraction, added to the error average on an error.
  localparam logic [15:0] AVG_HALF = 16'h8000;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 216;

  typedef struct packed {
    logic [15:0] consec_err_threshold;
    logic [31:0] hibernate_ms;
    logic [31:0] job_timeout_ms;
    logic [15:0] enabled_mask;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        access_ok;
    logic        result_ready;
    logic        write_allow;
    logic [2:0]  nonces_accepted;
    logic        readout_ok;
    logic        work_available;
    logic        job_write_ok;
  } poll_t;

  typedef struct packed {
    mode_e       mode;
    logic        has_work;
    logic [31:0] work_deadline;
    logic [31:0] wake_deadline;
    logic [7:0]  work_nonces;
    logic        low_seen;
    logic [15:0] consec;
    logic [15:0] max_consec;
    logic [31:0] hw_err;
    logic [15:0] average;
    logic [31:0] works;
    logic [31:0] with_nonce;
    logic [31:0] without_nonce;
    logic [31:0] nonce_total;
  } chip_state_t;

  typedef struct packed {
    logic release_work;
    logic take_work;
    logic reset_chip;
  } flags_t;

  typedef struct packed {
    logic [1:0]  chip_mode;
    flags_t      flags;
    logic [15:0] consec_errors;
    logic [15:0] max_consec_errors;
    logic [31:0] hw_error_count;
    logic [15:0] error_average;
    logic [31:0] works_taken;
    logic [31:0] works_with_nonce;
    logic [31:0] works_without_nonce;
    logic [31:0] accepted_nonces;
  } result_t;

endpackage

@@ design/chs_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_cfg: configuration registers
// Holds the error threshold, the hibernation and work time limits and the
// chip enable mask, written through a simple indexed write port.
// ----------------------------------------------------------------------------
module chs_cfg
  import chs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.consec_err_threshold <= RST_THRESHOLD;
      cfg_q.hibernate_ms         <= RST_HIBERNATE;
      cfg_q.job_timeout_ms       <= RST_WORK_TMO;
      cfg_q.enabled_mask         <= RST_ENABLE_MASK;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:   cfg_q.consec_err_threshold <= cfg_data_i[15:0];
        CFG_HIBERNATE:   cfg_q.hibernate_ms         <= cfg_data_i;
        CFG_WORK_TMO:    cfg_q.job_timeout_ms       <= cfg_data_i;
        CFG_ENABLE_MASK: cfg_q.enabled_mask         <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/chs_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_update: per-poll state update
// Computes the new state of the polled chip and the work handshake flags
// from its stored state, the poll outcomes and the configuration.
// ----------------------------------------------------------------------------
module chs_update
  import chs_pkg::*;
(
  input  cfg_t        cfg_i,
  input  poll_t       poll_i,
  input  logic        enabled_i,
  input  chip_state_t cur_i,
  output chip_state_t next_o,
  output flags_t      flags_o
);

  // A deadline has passed when now minus deadline is positive as a signed number.
  function automatic logic deadline_passed(input logic [31:0] deadline,
                                           input logic [31:0] now);
    logic [31:0] diff;
    diff = now - deadline;
    return (diff != 32'd0) && !diff[31];
  endfunction

  function automatic chip_state_t finish_work(input chip_state_t s, input logic err);
    chip_state_t r;
    r = s;
    if (r.work_nonces != 8'd0) begin
      r.with_nonce = r.with_nonce + 32'd1;
    end else begin
      r.without_nonce = r.without_nonce + 32'd1;
    end
    if (err) begin
      if (r.consec != 16'hFFFF) begin
        r.consec = r.consec + 16'd1;
      end
      if (r.max_consec < r.consec) begin
        r.max_consec = r.consec;
      end
      r.hw_err  = r.hw_err + 32'd1;
      r.average = (r.average >> 1) + AVG_HALF;
    end else begin
      r.consec  = 16'd0;
      r.average = r.average >> 1;
    end
    return r;
  endfunction

  function automatic chip_state_t drop_work(input chip_state_t s);
    chip_state_t r;
    r = s;
    r.has_work      = 1'b0;
    r.work_deadline = 32'd0;
    r.work_nonces   = 8'd0;
    r.low_seen      = 1'b0;
    return r;
  endfunction

  function automatic chip_state_t error_path(input chip_state_t s, input logic [15:0] limit);
    chip_state_t r;
    r = finish_work(s, 1'b1);
    if (r.consec > limit) begin
      r.mode = MODE_HIB_PEND;
    end
    r = drop_work(r);
    return r;
  endfunction

  function automatic chip_state_t add_nonces(input chip_state_t s, input logic [2:0] acc);
    chip_state_t r;
    logic [8:0]  sum;
    r   = s;
    sum = {1'b0, r.work_nonces} + {6'd0, acc};
    r.work_nonces = sum[8] ? 8'hFF : sum[7:0];
    r.nonce_total = r.nonce_total + {29'd0, acc};
    return r;
  endfunction

  chip_state_t c;
  flags_t      f;
  logic        try_take;
  logic [15:0] thr;

  assign thr = cfg_i.consec_err_threshold;

  always_comb begin
    c        = cur_i;
    f        = '0;
    try_take = 1'b0;
    if (enabled_i) begin
      case (cur_i.mode)
        MODE_RUN: begin
          if (c.has_work) begin
            if (!poll_i.access_ok) begin
              c = error_path(c, thr);
              f.release_work = 1'b1;
              f.reset_chip   = 1'b1;
            end else if (poll_i.result_ready && !poll_i.readout_ok) begin
              c = add_nonces(c, poll_i.nonces_accepted);
              c = error_path(c, thr);
              f.release_work = 1'b1;
              f.reset_chip   = 1'b1;
            end else begin
              if (poll_i.result_ready) begin
                c = add_nonces(c, poll_i.nonces_accepted);
              end
              if (poll_i.write_allow) begin
                // A work that found nothing and never dropped write-allow is a fault.
                if (c.work_nonces == 8'd0 && !c.low_seen) begin
                  c = error_path(c, thr);
                  f.release_work = 1'b1;
                  f.reset_chip   = 1'b1;
                end else begin
                  c = finish_work(c, 1'b0);
                  c = drop_work(c);
                  f.release_work = 1'b1;
                  try_take       = 1'b1;
                end
              end else begin
                c.low_seen = 1'b1;
                if (deadline_passed(c.work_deadline, poll_i.now_ms)) begin
                  c = error_path(c, thr);
                  f.release_work = 1'b1;
                  f.reset_chip   = 1'b1;
                end
              end
            end
          end else begin
            try_take = 1'b1;
          end
          if (try_take && poll_i.work_available) begin
            c.has_work      = 1'b1;
            c.work_deadline = poll_i.now_ms + cfg_i.job_timeout_ms;
            c.works         = c.works + 32'd1;
            c.work_nonces   = 8'd0;
            c.low_seen      = 1'b0;
            f.take_work     = 1'b1;
            if (!poll_i.job_write_ok) begin
              c = error_path(c, thr);
              f.release_work = 1'b1;
              f.reset_chip   = 1'b1;
            end
          end
        end
        MODE_HIB_PEND: begin
          c.consec        = 16'd0;
          c.wake_deadline = poll_i.now_ms + cfg_i.hibernate_ms;
          c.mode          = MODE_HIBERNATE;
        end
        default: begin
          if (deadline_passed(c.wake_deadline, poll_i.now_ms)) begin
            c.mode = MODE_RUN;
          end
        end
      endcase
    end
  end

  assign next_o  = c;
  assign flags_o = f;

endmodule

@@ design/chs_outreg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_outreg: result register
// Holds one finished result until the downstream side takes it and packs
// the result fields onto the output stream.
// ----------------------------------------------------------------------------
module chs_outreg
  import chs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  result_t               result_i,
  output logic                  free_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = load_i || (valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {3'd0,
                          res_q.accepted_nonces,
                          res_q.works_without_nonce,
                          res_q.works_with_nonce,
                          res_q.works_taken,
                          res_q.error_average,
                          res_q.hw_error_count,
                          res_q.max_consec_errors,
                          res_q.consec_errors,
                          res_q.flags.reset_chip,
                          res_q.flags.take_work,
                          res_q.flags.release_work,
                          res_q.chip_mode};

endmodule

@@ design/chip_health_supervisor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip_health_supervisor: per-chip health supervisor for a bank of chips
//
//   Channel   Direction  Transfer carries
//   s_axis    in         one poll of one chip (tuser: chip index)
//   m_axis    out        mode, work flags and statistics of that chip
//   cfg       in         register write, no read-back
//
// One poll per cycle is taken unless the output stalls; its result passes the
// input register, then the result register, before it can be transferred. The
// per-chip state sits in flops read and rewritten in the same cycle, so polls
// of the same chip may follow back to back. Reset clears all per-chip state
// at once; no clearing pass.
// A stalled output holds the result register and then the input register.
// ----------------------------------------------------------------------------
module chip_health_supervisor
  import chs_pkg::*;
#(
  parameter int unsigned CHIPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] now_ms, [32] access_ok, [33] result_ready, [34] write_allow,
  // [37:35] nonces_accepted, [38] readout_ok, [39] work_available,
  // [40] job_write_ok, [47:41] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [3:0] chip
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] chip_mode, [2] release_work, [3] take_work, [4] reset_chip,
  // [20:5] consec_errors, [36:21] max_consec_errors, [68:37] hw_error_count,
  // [84:69] error_average, [116:85] works_taken, [148:117] works_with_nonce,
  // [180:149] works_without_nonce, [212:181] accepted_nonces, [215:213] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W   = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam logic [6:0]  CHIPS_L = 7'(CHIPS);

  cfg_t        cfg;
  logic        s1_valid_q;
  logic        s1_valid_d;
  logic [3:0]  s1_chip_q;
  poll_t       s1_poll_q;
  poll_t       poll_in;
  logic        out_free;
  logic        s1_fire;
  logic        in_range;
  logic        enabled;
  logic [IDX_W-1:0] idx;
  chip_state_t chips_q [CHIPS];
  chip_state_t cur;
  chip_state_t nxt;
  flags_t      flags;
  result_t     res;

  chs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign poll_in.now_ms          = s_axis_tdata[31:0];
  assign poll_in.access_ok       = s_axis_tdata[32];
  assign poll_in.result_ready    = s_axis_tdata[33];
  assign poll_in.write_allow     = s_axis_tdata[34];
  assign poll_in.nonces_accepted = s_axis_tdata[37:35];
  assign poll_in.readout_ok      = s_axis_tdata[38];
  assign poll_in.work_available  = s_axis_tdata[39];
  assign poll_in.job_write_ok    = s_axis_tdata[40];

  assign s1_fire       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign s1_valid_d    = (s_axis_tvalid && s_axis_tready) || (s1_valid_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_chip_q <= s_axis_tuser;
      s1_poll_q <= poll_in;
    end
  end

  assign in_range = {3'd0, s1_chip_q} < CHIPS_L;
  assign idx      = IDX_W'(s1_chip_q);
  assign enabled  = cfg.enabled_mask[s1_chip_q];
  assign cur      = in_range ? chips_q[idx] : '0;

  chs_update u_update (
    .cfg_i     (cfg),
    .poll_i    (s1_poll_q),
    .enabled_i (enabled),
    .cur_i     (cur),
    .next_o    (nxt),
    .flags_o   (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHIPS; i++) begin
        chips_q[i] <= '0;
      end
    end else if (s1_fire && in_range) begin
      chips_q[idx] <= nxt;
    end
  end

  // A chip index beyond the bank yields an all-zero result.
  always_comb begin
    res = '0;
    if (in_range) begin
      res.chip_mode           = nxt.mode;
      res.flags               = flags;
      res.consec_errors       = nxt.consec;
      res.max_consec_errors   = nxt.max_consec;
      res.hw_error_count      = nxt.hw_err;
      res.error_average       = nxt.average;
      res.works_taken         = nxt.works;
      res.works_with_nonce    = nxt.with_nonce;
      res.works_without_nonce = nxt.without_nonce;
      res.accepted_nonces     = nxt.nonce_total;
    end
  end

  chs_outreg u_outreg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s1_fire),
    .result_i      (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> m_axis_tvalid)
    else $error("processed poll did not produce a result");

  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !in_range) |=> (m_axis_tdata == '0))
    else $error("result of a chip beyond the bank is not zero");

  a_reset_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && flags.reset_chip) |-> flags.release_work)
    else $error("chip reset without releasing its work");

  a_disabled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !enabled) |-> (flags == '0 && nxt == cur))
    else $error("disabled chip changed state");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the chip health supervisor
// Polls are queued by a stimulus process and sent by a driver with random
// gaps. Each accepted poll updates a model of the per-chip state kept in the
// bench, and the predicted status is compared field by field with the
// returned transfer while the output side stalls at random.
// ----------------------------------------------------------------------------
module tb
  import chs_pkg::*;
();

  localparam int CHIP_COUNT = 16;

  typedef struct {
    logic [3:0] chip;
    poll_t      poll;
    bit         hold;  // wait until every pending status has come back
  } poll_item_t;

  typedef struct {
    mode_e       mode;
    bit          busy;
    bit [31:0]   work_due;
    bit [31:0]   wake_due;
    bit [7:0]    found;
    bit          low_seen;
    bit [15:0]   consec;
    bit [15:0]   max_consec;
    bit [31:0]   hw_err;
    bit [15:0]   avg;
    bit [31:0]   works;
    bit [31:0]   with_nonce;
    bit [31:0]   without_nonce;
    bit [31:0]   nonces;
  } chip_rec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  chip_health_supervisor #(.CHIPS(CHIP_COUNT)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state and configuration.
  chip_rec_t  bank [CHIP_COUNT];
  bit [15:0]  err_limit  = RST_THRESHOLD;
  bit [31:0]  sleep_ms   = RST_HIBERNATE;
  bit [31:0]  work_ms    = RST_WORK_TMO;
  bit [15:0]  en_mask    = RST_ENABLE_MASK;
  bit         rel_f;
  bit         take_f;
  bit         rst_f;

  poll_item_t            poll_q [$];
  logic [OUT_DATA_W-1:0] status_q [$];
  bit [31:0]             wall_ms;
  int                    bad_cnt;
  int                    shown;
  bit                    in_fire;
  int                    send_gap;
  int                    send_burst;
  int                    recv_gap;
  int                    recv_burst;

  function automatic bit due_passed(bit [31:0] due, bit [31:0] now);
    bit [31:0] lag;
    lag = now - due;
    return lag != 0 && !lag[31];
  endfunction

  function automatic void close_work(int c, bit failed);
    if (bank[c].found != 0) bank[c].with_nonce++;
    else bank[c].without_nonce++;
    if (failed) begin
      if (bank[c].consec != 16'hFFFF) bank[c].consec++;
      if (bank[c].max_consec < bank[c].consec) bank[c].max_consec = bank[c].consec;
      bank[c].hw_err++;
      bank[c].avg = (bank[c].avg >> 1) + AVG_HALF;
    end else begin
      bank[c].consec = 0;
      bank[c].avg = bank[c].avg >> 1;
    end
  endfunction

  function automatic void give_back(int c);
    bank[c].busy     = 1'b0;
    bank[c].work_due = 0;
    bank[c].found    = 0;
    bank[c].low_seen = 1'b0;
    rel_f = 1'b1;
  endfunction

  function automatic void fault(int c);
    close_work(c, 1'b1);
    if (bank[c].consec > err_limit) bank[c].mode = MODE_HIB_PEND;
    give_back(c);
    rst_f = 1'b1;
  endfunction

  function automatic void run_poll(int c, poll_t p);
    bit [8:0] sum;
    if (bank[c].busy) begin
      if (!p.access_ok) begin
        fault(c);
        return;
      end
      if (p.result_ready) begin
        sum = {1'b0, bank[c].found} + {6'd0, p.nonces_accepted};
        bank[c].found = sum[8] ? 8'd255 : sum[7:0];
        bank[c].nonces += {29'd0, p.nonces_accepted};
        if (!p.readout_ok) begin
          fault(c);
          return;
        end
      end
      if (p.write_allow) begin
        // Write-allow high with no nonce and never seen low means a stuck chip.
        if (bank[c].found == 0 && !bank[c].low_seen) begin
          fault(c);
          return;
        end
        close_work(c, 1'b0);
        give_back(c);
      end else begin
        bank[c].low_seen = 1'b1;
        if (due_passed(bank[c].work_due, p.now_ms)) fault(c);
        return;
      end
    end
    if (!p.work_available) return;
    bank[c].busy     = 1'b1;
    bank[c].work_due = p.now_ms + work_ms;
    bank[c].works++;
    bank[c].found    = 0;
    bank[c].low_seen = 1'b0;
    take_f = 1'b1;
    if (!p.job_write_ok) fault(c);
  endfunction

  // Applies one poll to the model and returns the status it should produce.
  function automatic logic [OUT_DATA_W-1:0] supervise_poll(logic [3:0] chip, poll_t p);
    int c;
    c = int'(chip);
    rel_f  = 1'b0;
    take_f = 1'b0;
    rst_f  = 1'b0;
    if (c >= CHIP_COUNT) return '0;
    if (en_mask[chip]) begin
      case (bank[c].mode)
        MODE_RUN: begin
          run_poll(c, p);
        end
        MODE_HIB_PEND: begin
          bank[c].consec   = 0;
          bank[c].wake_due = p.now_ms + sleep_ms;
          bank[c].mode     = MODE_HIBERNATE;
        end
        default: begin
          if (due_passed(bank[c].wake_due, p.now_ms)) bank[c].mode = MODE_RUN;
        end
      endcase
    end
    return {3'b0, bank[c].nonces, bank[c].without_nonce, bank[c].with_nonce,
            bank[c].works, bank[c].avg, bank[c].hw_err, bank[c].max_consec,
            bank[c].consec, rst_f, take_f, rel_f, 2'(bank[c].mode)};
  endfunction

  function automatic logic [31:0] field_of(input logic [OUT_DATA_W-1:0] v, input int k,
                                           output string nm);
    case (k)
      0:  begin nm = "chip_mode";           return 32'(v[1:0]);     end
      1:  begin nm = "release_work";        return 32'(v[2]);       end
      2:  begin nm = "take_work";           return 32'(v[3]);       end
      3:  begin nm = "reset_chip";          return 32'(v[4]);       end
      4:  begin nm = "consec_errors";       return 32'(v[20:5]);    end
      5:  begin nm = "max_consec_errors";   return 32'(v[36:21]);   end
      6:  begin nm = "hw_error_count";      return v[68:37];        end
      7:  begin nm = "error_average";       return 32'(v[84:69]);   end
      8:  begin nm = "works_taken";         return v[116:85];       end
      9:  begin nm = "works_with_nonce";    return v[148:117];      end
      10: begin nm = "works_without_nonce"; return v[180:149];      end
      default: begin nm = "accepted_nonces"; return v[212:181];     end
    endcase
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: a new poll goes out once the previous one has been transferred.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (poll_q.size() > 0 && !(poll_q[0].hold && status_q.size() > 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= poll_q[0].chip;
        s_axis_tdata  <= {7'b0, poll_q[0].poll.job_write_ok, poll_q[0].poll.work_available,
                          poll_q[0].poll.readout_ok, poll_q[0].poll.nonces_accepted,
                          poll_q[0].poll.write_allow, poll_q[0].poll.result_ready,
                          poll_q[0].poll.access_ok, poll_q[0].poll.now_ms};
        poll_q.delete(0);
        send_gap <= (send_burst > 0) ? 0 : pick_gap();
        if (send_burst > 0) send_burst <= send_burst - 1;
        else if ($urandom_range(0, 49) == 0) send_burst <= $urandom_range(10, 40);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (recv_burst > 0) recv_burst <= recv_burst - 1;
        else if ($urandom_range(0, 49) == 0) recv_burst <= $urandom_range(10, 40);
        else if ($urandom_range(0, 2) == 0) recv_gap <= pick_gap();
      end
    end
  end

  // Monitor: predicts on every input transfer, checks every output transfer.
  always @(posedge clk_i) begin
    poll_t                 seen;
    logic [OUT_DATA_W-1:0] want;
    logic [31:0]           got_f;
    logic [31:0]           want_f;
    string                 nm;
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        seen.now_ms          = s_axis_tdata[31:0];
        seen.access_ok       = s_axis_tdata[32];
        seen.result_ready    = s_axis_tdata[33];
        seen.write_allow     = s_axis_tdata[34];
        seen.nonces_accepted = s_axis_tdata[37:35];
        seen.readout_ok      = s_axis_tdata[38];
        seen.work_available  = s_axis_tdata[39];
        seen.job_write_ok    = s_axis_tdata[40];
        status_q.push_back(supervise_poll(s_axis_tuser, seen));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_q.size() == 0) begin
          bad_cnt++;
          if (shown < 10) begin
            shown++;
            $display("%0t: status transfer with none expected: %h", $realtime, m_axis_tdata);
          end
        end else begin
          want = status_q.pop_front();
          for (int k = 0; k < 12; k++) begin
            want_f = field_of(want, k, nm);
            got_f  = field_of(m_axis_tdata, k, nm);
            if (got_f !== want_f) begin
              bad_cnt++;
              if (shown < 10) begin
                shown++;
                $display("%0t: %s mismatch: expected %0h, got %0h",
                         $realtime, nm, want_f, got_f);
              end
            end
          end
        end
      end
    end
  end

  task automatic add_poll(logic [3:0] chip, logic [31:0] now, bit acc, bit rr, bit wa,
                          logic [2:0] n, bit rok, bit av, bit jok);
    poll_item_t it;
    it.chip = chip;
    it.hold = 1'b0;
    it.poll.now_ms          = now;
    it.poll.access_ok       = acc;
    it.poll.result_ready    = rr;
    it.poll.write_allow     = wa;
    it.poll.nonces_accepted = n;
    it.poll.readout_ok      = rok;
    it.poll.work_available  = av;
    it.poll.job_write_ok    = jok;
    poll_q.push_back(it);
  endtask

  // Mostly plausible polls on a few busy chips, with some pure noise mixed in.
  task automatic queue_random(int n);
    poll_item_t  it;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) wall_ms += $urandom_range(0, 20);
      else if (r < 96) wall_ms += $urandom_range(21, 300);
      else wall_ms += $urandom_range(301, 30000);
      it.chip = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      it.hold = ($urandom_range(0, 79) == 0);
      if ($urandom_range(0, 9) == 0) begin
        it.poll.now_ms = $urandom;
        {it.poll.access_ok, it.poll.result_ready, it.poll.write_allow,
         it.poll.nonces_accepted, it.poll.readout_ok, it.poll.work_available,
         it.poll.job_write_ok} = 9'($urandom);
      end else begin
        it.poll.now_ms          = wall_ms;
        it.poll.access_ok       = ($urandom_range(0, 19) != 0);
        it.poll.result_ready    = 1'($urandom_range(0, 1));
        it.poll.write_allow     = ($urandom_range(0, 9) < 6);
        it.poll.nonces_accepted = ($urandom_range(0, 19) != 0) ? 3'($urandom_range(0, 4))
                                                               : 3'($urandom_range(5, 7));
        it.poll.readout_ok      = ($urandom_range(0, 19) != 0);
        it.poll.work_available  = ($urandom_range(0, 9) < 7);
        it.poll.job_write_ok    = ($urandom_range(0, 19) != 0);
      end
      poll_q.push_back(it);
    end
  endtask

  // Waits until the block has nothing left in flight.
  task automatic settle();
    do @(posedge clk_i);
    while (poll_q.size() != 0 || s_axis_tvalid || status_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_THRESHOLD: err_limit = data[15:0];
      CFG_HIBERNATE: sleep_ms  = data;
      CFG_WORK_TMO:  work_ms   = data;
      default:       en_mask   = data[15:0];
    endcase
  endtask

  task automatic reconfigure(logic [31:0] thr, logic [31:0] hib, logic [31:0] tmo,
                             logic [31:0] mask);
    settle();
    set_reg(CFG_THRESHOLD, thr);
    set_reg(CFG_HIBERNATE, hib);
    set_reg(CFG_WORK_TMO, tmo);
    set_reg(CFG_ENABLE_MASK, mask);
  endtask

  initial begin
    for (int i = 0; i < CHIP_COUNT; i++) bank[i].mode = MODE_RUN;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Chip 0 walks through take, finish, every error kind but a failed readout, hibernation and wake.
    add_poll(0, 32'd0,     1, 0, 1, 0, 1, 1, 1);
    add_poll(0, 32'd10,    1, 0, 0, 0, 1, 0, 1);
    add_poll(0, 32'd20,    1, 1, 1, 4, 1, 1, 1);
    add_poll(0, 32'd30,    0, 0, 0, 0, 1, 1, 1);
    add_poll(0, 32'd40,    1, 0, 1, 0, 1, 1, 0);
    add_poll(0, 32'd50,    1, 0, 1, 0, 1, 1, 1);
    add_poll(0, 32'd60,    1, 0, 1, 0, 1, 0, 1);
    add_poll(0, 32'd70,    1, 0, 1, 0, 1, 1, 1);
    add_poll(0, 32'd5070,  1, 0, 0, 0, 1, 0, 1);
    add_poll(0, 32'd5071,  1, 0, 0, 0, 1, 0, 1);
    add_poll(0, 32'd5080,  1, 0, 1, 0, 1, 1, 1);
    add_poll(0, 32'd15080, 1, 0, 1, 0, 1, 1, 1);
    add_poll(0, 32'd15081, 1, 0, 1, 0, 1, 1, 1);
    add_poll(0, 32'd15090, 1, 0, 1, 0, 1, 1, 1);
    // Deadline across the time wrap, then a failed readout with an oversized count.
    add_poll(1, 32'hFFFF_FFFF, 1, 0, 1, 0, 1, 1, 1);
    add_poll(1, 32'd100,   1, 1, 0, 7, 0, 0, 1);
    // Clean finish without a nonce after write-allow was seen low.
    add_poll(2, 32'd200,   1, 0, 1, 0, 1, 1, 1);
    add_poll(2, 32'd210,   1, 0, 0, 0, 1, 0, 1);
    add_poll(2, 32'd220,   1, 0, 1, 0, 1, 0, 1);
    // Highest chip index with all bits set, then all bits clear.
    add_poll(15, 32'hFFFF_FFFF, 1, 1, 1, 7, 1, 1, 1);
    add_poll(15, 32'd0,         1, 1, 1, 7, 1, 1, 1);
    add_poll(15, 32'd0,         0, 0, 0, 0, 0, 0, 0);

    reconfigure(32'd0, 32'd0, 32'd0, 32'h0000_FFFF);
    wall_ms = $urandom;
    queue_random(120);

    // Upper bits of the narrow registers must be ignored.
    reconfigure(32'hABCD_0001, 32'd40, 32'd60, {16'h5A5A, 16'($urandom)});
    queue_random(130);

    reconfigure(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    queue_random(30);
    reconfigure(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
    queue_random(60);

    reconfigure(32'd2, 32'd25, 32'd30, 32'($urandom_range(0, 65535)));
    wall_ms = 32'hFFFF_FF00;
    queue_random(150);

    reconfigure(32'd3, 32'd10000, 32'd5000, 32'h0000_FFFF);
    queue_random(150);

    reconfigure($urandom_range(0, 4), $urandom_range(0, 100), $urandom_range(0, 200),
                32'($urandom_range(0, 65535)));
    queue_random(80);

    settle();
    bad_cnt += status_q.size();
    if (bad_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
